// ----- sv/volume_central_difference_gradient_unit_macros.svh -----
// Assertion macros shared by the gradient unit RTL.
// No dependencies; the using module must have signals named clock and reset.
`ifndef VOLUME_CENTRAL_DIFFERENCE_GRADIENT_UNIT_MACROS_SVH
`define VOLUME_CENTRAL_DIFFERENCE_GRADIENT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define VCDG_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define VCDG_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/vcdg_pkg.sv -----
// Package for the volume gradient unit: field widths, size defaults, CSR codes.
// No dependencies.
package vcdg_pkg;

   // Default maximum volume dimensions.
   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;
   localparam int DEF_MAX_DEPTH  = 256;

   // Item field widths.
   localparam int VOXEL_W = 16;
   localparam int GRAD_W  = 16;
   localparam int POSX_W  = 6;
   localparam int POSY_W  = 6;
   localparam int POSZ_W  = 8;

   // Configuration register widths and reset values.
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 9;
   localparam int CSR_WIDTH_W  = 7;
   localparam int CSR_HEIGHT_W = 7;
   localparam int CSR_DEPTH_W  = 9;
   localparam logic [CSR_WIDTH_W-1:0]  CSR_WIDTH_RST  = 7'd64;
   localparam logic [CSR_HEIGHT_W-1:0] CSR_HEIGHT_RST = 7'd64;
   localparam logic [CSR_DEPTH_W-1:0]  CSR_DEPTH_RST  = 9'd256;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLUME_WIDTH  = 2'd0,
      CSR_VOLUME_HEIGHT = 2'd1,
      CSR_VOLUME_DEPTH  = 2'd2
   } csr_index_type;

endpackage

// ----- sv/vcdg_if.sv -----
// Valid/ready channel interfaces for the gradient unit's input and result items.
// Depends on vcdg_pkg.
interface vcdg_req_if
   import vcdg_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [VOXEL_W-1:0] voxel_value;

   modport source (output valid, output voxel_value, input ready);
   modport sink   (input valid, input voxel_value, output ready);
endinterface

interface vcdg_rsp_if
   import vcdg_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [GRAD_W-1:0] grad_x;
   logic signed [GRAD_W-1:0] grad_y;
   logic signed [GRAD_W-1:0] grad_z;
   logic [POSX_W-1:0]        pos_x;
   logic [POSY_W-1:0]        pos_y;
   logic [POSZ_W-1:0]        pos_z;
   logic                     flat_region;
   logic                     final_voxel;

   modport source (output valid, output grad_x, output grad_y, output grad_z,
                   output pos_x, output pos_y, output pos_z,
                   output flat_region, output final_voxel, input ready);
   modport sink   (input valid, input grad_x, input grad_y, input grad_z,
                   input pos_x, input pos_y, input pos_z,
                   input flat_region, input final_voxel, output ready);
endinterface

// ----- sv/vcdg_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module vcdg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/volume_central_difference_gradient_unit.sv -----
// Streams voxels in raster order (x fastest, then y, then z) and emits the unit
// central-difference gradient of interior voxel (x,y,z) when voxel (x,y,z+1) arrives.
// Two planes live in one RAM; the voxel itself and four neighbors are read one per
// cycle, then the new voxel is written. A border voxel is only written. For an interior
// voxel the time is set by one shared bit-serial unit that for each component divides
// and then takes a square root. The gradient is signed Q1.14, rounded half away from
// zero; an all-zero difference gives zero and flat_region. Sizes saturate to [3, MAX].
// Depends on vcdg_pkg, vcdg_if, vcdg_ram and the macros header.
`include "volume_central_difference_gradient_unit_macros.svh"

module volume_central_difference_gradient_unit
   import vcdg_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_DEPTH  = DEF_MAX_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   vcdg_req_if.sink              req_chan,
   vcdg_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int ZW    = $clog2(MAX_DEPTH);
   localparam int SXW   = XW + 1;
   localparam int SYW   = YW + 1;
   localparam int SZW   = ZW + 1;
   localparam int PLANE = MAX_WIDTH * MAX_HEIGHT;
   localparam int RDEP  = 2 * PLANE;
   localparam int AW    = $clog2(RDEP);
   localparam int NB_N  = 5;
   localparam int NBW   = $clog2(NB_N + 1);
   localparam logic [NBW-1:0] RD_LAST = NBW'(NB_N);

   typedef enum logic [3:0] {
      ST_IDLE, ST_WR, ST_RD, ST_SQ, ST_SUM, ST_PREP, ST_DIV, ST_SQRT, ST_OUT
   } state_type;

   // Configuration registers.
   logic [CSR_WIDTH_W-1:0]  width_ff;
   logic [CSR_HEIGHT_W-1:0] height_ff;
   logic [CSR_DEPTH_W-1:0]  depth_ff;

   // Position counters of the next voxel.
   logic [XW-1:0] col_ff;
   logic [YW-1:0] row_ff;
   logic [ZW-1:0] plane_ff;

   // Current item.
   state_type          state_ff;
   logic [XW-1:0]      x_ff;
   logic [YW-1:0]      y_ff;
   logic [ZW-1:0]      p_ff;
   logic [VOXEL_W-1:0] cur_ff;
   logic               final_ff;
   logic [NBW-1:0]     rd_idx_ff;
   logic [VOXEL_W-1:0] nb_ff [NB_N];
   logic [1:0]         comp_ff;
   logic [31:0]        mag2_ff [3];
   logic [2:0]         neg_ff;
   logic [33:0]        s_ff;
   logic [34:0]        rem_ff;
   logic [30:0]        sh_ff;
   logic [30:0]        quo_ff;
   logic [4:0]         cnt_ff;
   logic [31:0]        rad_ff;
   logic [17:0]        srem_ff;
   logic [15:0]        root_ff;
   logic               flat_ff;
   logic signed [GRAD_W-1:0] grad_ff [3];

   // Result register.
   logic                     rsp_valid_ff;
   logic signed [GRAD_W-1:0] rsp_gx_ff;
   logic signed [GRAD_W-1:0] rsp_gy_ff;
   logic signed [GRAD_W-1:0] rsp_gz_ff;
   logic [POSX_W-1:0]        rsp_px_ff;
   logic [POSY_W-1:0]        rsp_py_ff;
   logic [POSZ_W-1:0]        rsp_pz_ff;
   logic                     rsp_flat_ff;
   logic                     rsp_final_ff;

   logic [SXW-1:0] eff_w;
   logic [SYW-1:0] eff_h;
   logic [SZW-1:0] eff_d;
   logic [XW-1:0]  x_in;
   logic [YW-1:0]  y_in;
   logic [ZW-1:0]  p_in;
   logic           interior;
   logic           req_acc;
   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   logic [AW-1:0]  ram_raddr;
   logic [VOXEL_W-1:0] ram_rdata;
   logic signed [16:0] d_sel;
   logic [15:0]    mag_sel;
   logic [34:0]    div_trial;
   logic           div_bit;
   logic [30:0]    quo_in;
   logic [17:0]    sq_next;
   logic [17:0]    sq_trial;
   logic           sq_bit;
   logic [15:0]    root_in;
   logic [16:0]    q_rnd;
   logic signed [GRAD_W-1:0] grad_in;
   logic           out_free;

   function automatic logic [AW-1:0] cell_addr(input logic slot, input logic [XW-1:0] cx,
                                               input logic [YW-1:0] cy);
      return AW'(32'(slot) * 32'(PLANE) + 32'(cy) * 32'(MAX_WIDTH) + 32'(cx));
   endfunction

   // Effective sizes, saturated into [3, MAX].
   assign eff_w = SXW'((32'(width_ff) < 32'd3) ? 32'd3 :
                  ((32'(width_ff) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(width_ff)));
   assign eff_h = SYW'((32'(height_ff) < 32'd3) ? 32'd3 :
                  ((32'(height_ff) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(height_ff)));
   assign eff_d = SZW'((32'(depth_ff) < 32'd3) ? 32'd3 :
                  ((32'(depth_ff) > 32'(MAX_DEPTH)) ? 32'(MAX_DEPTH) : 32'(depth_ff)));

   // Position of the arriving voxel; a counter past its size restarts at zero.
   assign x_in = ({1'b0, col_ff} >= eff_w) ? '0 : col_ff;
   assign y_in = ({1'b0, row_ff} >= eff_h) ? '0 : row_ff;
   assign p_in = ({1'b0, plane_ff} >= eff_d) ? '0 : plane_ff;

   assign interior = (32'(p_in) >= 32'd2) && (32'(x_in) >= 32'd1) &&
                     (32'(x_in) + 32'd2 <= 32'(eff_w)) && (32'(y_in) >= 32'd1) &&
                     (32'(y_in) + 32'd2 <= 32'(eff_h));

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;

   // Plane store: the voxel's own cell holds plane p-2, neighbors come from plane p-1.
   always_comb begin
      unique case (rd_idx_ff)
         NBW'(1):  ram_raddr = cell_addr(~p_ff[0], x_ff - XW'(1), y_ff);
         NBW'(2):  ram_raddr = cell_addr(~p_ff[0], x_ff + XW'(1), y_ff);
         NBW'(3):  ram_raddr = cell_addr(~p_ff[0], x_ff, y_ff - YW'(1));
         NBW'(4):  ram_raddr = cell_addr(~p_ff[0], x_ff, y_ff + YW'(1));
         default:  ram_raddr = cell_addr(p_ff[0], x_ff, y_ff);
      endcase
   end

   assign ram_we    = (state_ff == ST_WR) || ((state_ff == ST_RD) && (rd_idx_ff == RD_LAST));
   assign ram_waddr = cell_addr(p_ff[0], x_ff, y_ff);

   vcdg_ram #(.WIDTH(VOXEL_W), .DEPTH(RDEP)) u_plane_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (cur_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Difference of the selected axis: before minus after.
   always_comb begin
      unique case (comp_ff)
         2'd0:    d_sel = $signed({1'b0, nb_ff[1]}) - $signed({1'b0, nb_ff[2]});
         2'd1:    d_sel = $signed({1'b0, nb_ff[3]}) - $signed({1'b0, nb_ff[4]});
         default: d_sel = $signed({1'b0, nb_ff[0]}) - $signed({1'b0, cur_ff});
      endcase
      mag_sel = d_sel[16] ? 16'(-d_sel) : 16'(d_sel);
   end

   // One restoring divide step: quotient of mag^2 * 2^30 by the squared length.
   assign div_trial = {rem_ff[33:0], sh_ff[30]};
   assign div_bit   = (div_trial >= {1'b0, s_ff});
   assign quo_in    = {quo_ff[29:0], div_bit};

   // One square root step, two radicand bits at a time.
   assign sq_next  = {srem_ff[15:0], rad_ff[31:30]};
   assign sq_trial = {root_ff, 2'b01};
   assign sq_bit   = (sq_next >= sq_trial);
   assign root_in  = {root_ff[14:0], sq_bit};

   // Largest q with 2q-1 at most the root, then the sign of the difference.
   assign q_rnd   = (17'(root_in) + 17'd1) >> 1;
   assign grad_in = neg_ff[comp_ff] ? -GRAD_W'(q_rnd) : GRAD_W'(q_rnd);

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_WIDTH_RST;
         height_ff <= CSR_HEIGHT_RST;
         depth_ff  <= CSR_DEPTH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VOLUME_WIDTH:  width_ff  <= csr_wdata[CSR_WIDTH_W-1:0];
            CSR_VOLUME_HEIGHT: height_ff <= csr_wdata[CSR_HEIGHT_W-1:0];
            CSR_VOLUME_DEPTH:  depth_ff  <= csr_wdata[CSR_DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: plane store access, squares, then divide and root per component.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         plane_ff     <= '0;
         rd_idx_ff    <= '0;
         comp_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The result register empties here unless a new item is loaded below.
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  x_ff      <= x_in;
                  y_ff      <= y_in;
                  p_ff      <= p_in;
                  cur_ff    <= req_chan.voxel_value;
                  final_ff  <= (32'(x_in) + 32'd2 == 32'(eff_w)) &&
                               (32'(y_in) + 32'd2 == 32'(eff_h)) &&
                               (32'(p_in) + 32'd1 == 32'(eff_d));
                  rd_idx_ff <= '0;
                  state_ff  <= interior ? ST_RD : ST_WR;
                  // Advance the raster position.
                  if (32'(x_in) + 32'd1 >= 32'(eff_w)) begin
                     col_ff <= '0;
                     if (32'(y_in) + 32'd1 >= 32'(eff_h)) begin
                        row_ff <= '0;
                        plane_ff <= (32'(p_in) + 32'd1 >= 32'(eff_d)) ? '0 : p_in + ZW'(1);
                     end else begin
                        row_ff <= y_in + YW'(1);
                        plane_ff <= p_in;
                     end
                  end else begin
                     col_ff   <= x_in + XW'(1);
                     row_ff   <= y_in;
                     plane_ff <= p_in;
                  end
               end
            end
            ST_WR: begin
               state_ff <= ST_IDLE;
            end
            ST_RD: begin
               if (rd_idx_ff != '0) begin
                  nb_ff[rd_idx_ff - NBW'(1)] <= ram_rdata;
               end
               if (rd_idx_ff == RD_LAST) begin
                  comp_ff  <= '0;
                  state_ff <= ST_SQ;
               end else begin
                  rd_idx_ff <= rd_idx_ff + NBW'(1);
               end
            end
            ST_SQ: begin
               mag2_ff[comp_ff] <= 32'(mag_sel) * 32'(mag_sel);
               neg_ff[comp_ff]  <= d_sel[16];
               if (comp_ff == 2'd2) begin
                  state_ff <= ST_SUM;
               end else begin
                  comp_ff <= comp_ff + 2'd1;
               end
            end
            ST_SUM: begin
               s_ff     <= 34'(mag2_ff[0]) + 34'(mag2_ff[1]) + 34'(mag2_ff[2]);
               comp_ff  <= '0;
               state_ff <= ST_PREP;
            end
            ST_PREP: begin
               if (s_ff == '0) begin
                  flat_ff    <= 1'b1;
                  grad_ff[0] <= '0;
                  grad_ff[1] <= '0;
                  grad_ff[2] <= '0;
                  state_ff   <= ST_OUT;
               end else begin
                  flat_ff  <= 1'b0;
                  rem_ff   <= 35'(mag2_ff[comp_ff] >> 1);
                  sh_ff    <= {mag2_ff[comp_ff][0], 30'b0};
                  quo_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff <= div_bit ? (div_trial - {1'b0, s_ff}) : div_trial;
               sh_ff  <= {sh_ff[29:0], 1'b0};
               quo_ff <= quo_in;
               if (cnt_ff == 5'd30) begin
                  rad_ff   <= {1'b0, quo_in};
                  srem_ff  <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_SQRT;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            ST_SQRT: begin
               srem_ff <= sq_bit ? (sq_next - sq_trial) : sq_next;
               root_ff <= root_in;
               rad_ff  <= {rad_ff[29:0], 2'b00};
               if (cnt_ff == 5'd15) begin
                  grad_ff[comp_ff] <= grad_in;
                  if (comp_ff == 2'd2) begin
                     state_ff <= ST_OUT;
                  end else begin
                     comp_ff  <= comp_ff + 2'd1;
                     state_ff <= ST_PREP;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            ST_OUT: begin
               // Load the result register once the previous item has gone.
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_gx_ff    <= grad_ff[0];
                  rsp_gy_ff    <= grad_ff[1];
                  rsp_gz_ff    <= grad_ff[2];
                  rsp_px_ff    <= POSX_W'(x_ff);
                  rsp_py_ff    <= POSY_W'(y_ff);
                  rsp_pz_ff    <= POSZ_W'(p_ff - ZW'(1));
                  rsp_flat_ff  <= flat_ff;
                  rsp_final_ff <= final_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.grad_x      = rsp_gx_ff;
   assign rsp_chan.grad_y      = rsp_gy_ff;
   assign rsp_chan.grad_z      = rsp_gz_ff;
   assign rsp_chan.pos_x       = rsp_px_ff;
   assign rsp_chan.pos_y       = rsp_py_ff;
   assign rsp_chan.pos_z       = rsp_pz_ff;
   assign rsp_chan.flat_region = rsp_flat_ff;
   assign rsp_chan.final_voxel = rsp_final_ff;

   // Checks on the sequencer and the arithmetic.
   `VCDG_ASSERT_NXT(a_busy_after_accept, req_acc, !req_chan.ready, "ready while item in work")
   `VCDG_ASSERT_IMP(a_flat_zero, rsp_valid_ff && rsp_flat_ff,
      rsp_gx_ff == '0 && rsp_gy_ff == '0 && rsp_gz_ff == '0, "flat item with nonzero gradient")
   `VCDG_ASSERT_IMP(a_unit_range, rsp_valid_ff,
      rsp_gx_ff <= 16384 && rsp_gx_ff >= -16384 && rsp_gy_ff <= 16384 &&
      rsp_gy_ff >= -16384 && rsp_gz_ff <= 16384 && rsp_gz_ff >= -16384,
      "gradient component beyond unit range")
   `VCDG_ASSERT_IMP(a_div_rem, state_ff == ST_DIV, rem_ff < {1'b0, s_ff},
      "divider remainder not below divisor")

endmodule
